@@ hdl/hgt_pkg.sv @@
// shared types and constants of the generation-checked handle table
package hgt_pkg;

	localparam int SLOT_COUNT   = 64;
	localparam int GEN_BITS     = 16;
	localparam int USE_BITS     = 8;
	localparam int PAYLOAD_BITS = 32;
	localparam int KIND_W       = 4;
	localparam int OP_W         = 3;
	localparam int STATUS_W     = 3;
	localparam int IDX_W        = $clog2(SLOT_COUNT);
	localparam int DEPTH_W      = $clog2(SLOT_COUNT + 1);
	localparam int IN_W         = 64;
	localparam int OUT_W        = 64;
	localparam int IN_PAD_W     = IN_W - (OP_W + IDX_W + GEN_BITS + KIND_W + PAYLOAD_BITS);
	localparam int OUT_PAD_W    = OUT_W - (2 + STATUS_W + IDX_W + GEN_BITS + PAYLOAD_BITS);

	typedef enum logic [OP_W-1:0] {
		OP_RESERVE      = 3'd0,
		OP_PUBLISH      = 3'd1,
		OP_ABANDON      = 3'd2,
		OP_RESOLVE      = 3'd3,
		OP_RELEASE      = 3'd4,
		OP_CLOSE_BEGIN  = 3'd5,
		OP_CLOSE_FINISH = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		PH_FREE    = 3'd0,
		PH_OPENING = 3'd1,
		PH_LIVE    = 3'd2,
		PH_CLOSING = 3'd3,
		PH_RETIRED = 3'd4
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 3'd0,
		ST_NOFREE = 3'd1,
		ST_STALE  = 3'd2,
		ST_OVER   = 3'd3,
		ST_UNDER  = 3'd4
	} status_t;

	typedef struct packed {
		phase_t                  phase;
		logic [GEN_BITS-1:0]     gen;
		logic [KIND_W-1:0]       kind;
		logic [PAYLOAD_BITS-1:0] payload;
		logic [USE_BITS-1:0]     uses;
		logic                    fin;
	} slot_ent_t;

	typedef struct packed {
		logic [GEN_BITS-1:0] gen;
		logic [IDX_W-1:0]    slot;
	} stk_ent_t;

	// input tdata layout, op in the lowest bits
	typedef struct packed {
		logic [IN_PAD_W-1:0]     pad;
		logic [PAYLOAD_BITS-1:0] payload;
		logic [KIND_W-1:0]       kind;
		logic [GEN_BITS-1:0]     hgen;
		logic [IDX_W-1:0]        idx;
		logic [OP_W-1:0]         op;
	} item_t;

	// output tdata layout, ok in the lowest bit
	typedef struct packed {
		logic [OUT_PAD_W-1:0]    pad;
		logic                    recycled;
		logic [PAYLOAD_BITS-1:0] payload;
		logic [GEN_BITS-1:0]     gen;
		logic [IDX_W-1:0]        slot;
		status_t                 status;
		logic                    ok;
	} res_t;

	// table and stack updates of one executed item
	typedef struct packed {
		logic                 slot_we;
		logic [IDX_W-1:0]     slot_waddr;
		slot_ent_t            slot_wdata;
		logic                 push;
		logic                 pop;
		logic [IDX_W-1:0]     stk_waddr;
		stk_ent_t             stk_wdata;
		logic [DEPTH_W-1:0]   depth_nxt;
	} upd_t;

endpackage

@@ hdl/hgt_ram.sv @@
// generic single-port-write ram with registered read
module hgt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/hgt_exec.sv @@
// execute logic: one operation against one slot entry and the stack top
module hgt_exec (
	input  hgt_pkg::item_t                  item,
	input  hgt_pkg::slot_ent_t              ent,
	input  hgt_pkg::stk_ent_t               top,
	input  logic [hgt_pkg::DEPTH_W-1:0]     depth,
	output hgt_pkg::res_t                   res,
	output hgt_pkg::upd_t                   upd
);
	import hgt_pkg::*;

	slot_ent_t rec_e;
	logic      rec_push;
	logic      id_match;
	logic      can_push;

	// recycled image of the addressed slot
	always_comb begin
		rec_e         = ent;
		rec_e.payload = '0;
		rec_e.fin     = 1'b0;
		rec_e.uses    = '0;
		rec_push      = 1'b0;
		if (ent.gen == {GEN_BITS{1'b1}}) begin
			rec_e.phase = PH_RETIRED;
		end else begin
			rec_e.gen   = ent.gen + GEN_BITS'(1);
			rec_e.phase = PH_FREE;
			rec_push    = 1'b1;
		end
	end

	assign id_match = (ent.phase == PH_LIVE) && (ent.gen == item.hgen) && (ent.kind == item.kind);
	assign can_push = depth < DEPTH_W'(SLOT_COUNT);

	always_comb begin
		res            = '0;
		res.status     = ST_STALE;
		res.slot       = item.idx;
		upd            = '0;
		upd.slot_waddr = item.idx;
		upd.slot_wdata = ent;
		upd.stk_waddr  = depth[IDX_W-1:0];
		upd.stk_wdata  = '{gen: rec_e.gen, slot: item.idx};
		upd.depth_nxt  = depth;
		case (item.op)
			OP_RESERVE: begin
				if (depth == '0) begin
					res.status = ST_NOFREE;
				end else begin
					upd.pop        = 1'b1;
					upd.depth_nxt  = depth - DEPTH_W'(1);
					upd.slot_we    = 1'b1;
					upd.slot_waddr = top.slot;
					upd.slot_wdata = '{phase: PH_OPENING, gen: top.gen, kind: item.kind,
						payload: '0, uses: '0, fin: 1'b0};
					res.ok         = 1'b1;
					res.status     = ST_OK;
					res.slot       = top.slot;
					res.gen        = top.gen;
				end
			end
			OP_PUBLISH: begin
				if (ent.phase == PH_OPENING) begin
					upd.slot_we            = 1'b1;
					upd.slot_wdata.payload = item.payload;
					upd.slot_wdata.phase   = PH_LIVE;
					res.ok                 = 1'b1;
					res.status             = ST_OK;
				end
			end
			OP_ABANDON: begin
				if (ent.phase == PH_OPENING) begin
					upd.slot_we    = 1'b1;
					upd.slot_wdata = rec_e;
					upd.push       = rec_push && can_push;
					res.ok         = 1'b1;
					res.status     = ST_OK;
					res.recycled   = 1'b1;
				end
			end
			OP_RESOLVE: begin
				if (id_match) begin
					if (ent.uses == {USE_BITS{1'b1}}) begin
						res.status = ST_OVER;
					end else begin
						upd.slot_we         = 1'b1;
						upd.slot_wdata.uses = ent.uses + USE_BITS'(1);
						res.payload         = ent.payload;
						res.ok              = 1'b1;
						res.status          = ST_OK;
					end
				end
			end
			OP_RELEASE: begin
				if (ent.phase == PH_LIVE || ent.phase == PH_CLOSING) begin
					if (ent.uses == '0) begin
						res.status = ST_UNDER;
					end else begin
						upd.slot_we         = 1'b1;
						upd.slot_wdata.uses = ent.uses - USE_BITS'(1);
						res.ok              = 1'b1;
						res.status          = ST_OK;
						// last use gone with a close waiting
						if (ent.fin && ent.uses == USE_BITS'(1)) begin
							upd.slot_wdata = rec_e;
							upd.push       = rec_push && can_push;
							res.recycled   = 1'b1;
						end
					end
				end
			end
			OP_CLOSE_BEGIN: begin
				if (id_match) begin
					upd.slot_we          = 1'b1;
					upd.slot_wdata.phase = PH_CLOSING;
					res.payload          = ent.payload;
					res.ok               = 1'b1;
					res.status           = ST_OK;
				end
			end
			OP_CLOSE_FINISH: begin
				if (ent.phase == PH_CLOSING) begin
					upd.slot_we        = 1'b1;
					upd.slot_wdata.fin = 1'b1;
					res.ok             = 1'b1;
					res.status         = ST_OK;
					if (ent.uses == '0) begin
						upd.slot_wdata = rec_e;
						upd.push       = rec_push && can_push;
						res.recycled   = 1'b1;
					end
				end
			end
			default: begin
				res.status = ST_STALE;
			end
		endcase
		if (upd.push) begin
			upd.depth_nxt = depth + DEPTH_W'(1);
		end
	end

endmodule

@@ hdl/generation_checked_handle_table_unit.sv @@
// top level of the generation-checked handle table
// A table of 64 slots that hands out handles (slot index plus 16-bit generation) and
// checks them on resolve and close-begin. One item enters per clock while the output is
// not stalled: an accepted item is registered together with the registered reads of its
// slot entry and of the free-stack top, is executed by short logic in the next cycle, and
// its result is written to the output register once that register is free or being taken,
// so a new item can follow in every cycle unless the output stalls. That rate is set by
// the slot table and the free stack, each a ram with one write and one registered read
// per cycle; a write that lands on the entry read in the same cycle is forwarded into
// the stage. Per-entry valid bits stand for the reset contents, so the block needs no
// clearing pass and accepts items right after reset. The output register holds a
// finished result while the next item is taken in.
module generation_checked_handle_table_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// op[2:0], slot_index[8:3], handle_generation[24:9], kind[28:25], payload[60:29], zeros
	input  logic [hgt_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// ok[0], status[3:1], out_slot[9:4], out_generation[25:10], out_payload[57:26],
	// recycled[58], zeros
	output logic [hgt_pkg::OUT_W-1:0] m_tdata
);
	import hgt_pkg::*;

	localparam int SLOT_W = $bits(slot_ent_t);
	localparam int STK_W  = $bits(stk_ent_t);

	item_t                 in_item;
	logic                  accept;
	logic                  go;

	// execute stage
	logic                  vld_s1;
	item_t                 item_s1;
	logic                  slot_vld_s1;
	logic                  slot_hit_s1;
	slot_ent_t             slot_byp_s1;
	logic                  stk_vld_s1;
	logic                  stk_hit_s1;
	stk_ent_t              stk_byp_s1;
	logic [IDX_W-1:0]      stk_addr_s1;

	// bookkeeping
	logic [DEPTH_W-1:0]    depth_q;
	logic [SLOT_COUNT-1:0] slot_vld_q;
	logic [SLOT_COUNT-1:0] stk_vld_q;

	logic [SLOT_W-1:0]     slot_rdata;
	logic [STK_W-1:0]      stk_rdata;
	slot_ent_t             ent;
	stk_ent_t              top;
	res_t                  res;
	upd_t                  upd;
	logic                  slot_we;
	logic                  stk_we;
	logic [DEPTH_W-1:0]    depth_nxt;
	logic [IDX_W-1:0]      stk_raddr;
	logic                  slot_fwd;
	logic                  stk_fwd;

	logic                  out_vld_q;
	res_t                  out_q;

	assign in_item  = item_t'(s_tdata);
	assign go       = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || go;
	assign accept   = s_tvalid && s_tready;

	// table and stack updates only land when the item leaves the stage
	assign slot_we   = go && upd.slot_we;
	assign stk_we    = go && upd.push;
	assign depth_nxt = go ? upd.depth_nxt : depth_q;
	// the next item reads the stack top as it will stand after this item
	assign stk_raddr = IDX_W'(depth_nxt - DEPTH_W'(1));
	assign slot_fwd  = slot_we && (upd.slot_waddr == in_item.idx);
	assign stk_fwd   = stk_we && (upd.stk_waddr == stk_raddr);

	hgt_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(SLOT_COUNT)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (upd.slot_waddr),
		.wdata (upd.slot_wdata),
		.re    (accept),
		.raddr (in_item.idx),
		.rdata (slot_rdata)
	);

	hgt_ram #(
		.WIDTH(STK_W),
		.DEPTH(SLOT_COUNT)
	) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (upd.stk_waddr),
		.wdata (upd.stk_wdata),
		.re    (accept),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// unwritten entries read as their reset contents
	always_comb begin
		if (!slot_vld_s1) begin
			ent = '0;
		end else if (slot_hit_s1) begin
			ent = slot_byp_s1;
		end else begin
			ent = slot_ent_t'(slot_rdata);
		end
		if (!stk_vld_s1) begin
			top = '{gen: '0, slot: stk_addr_s1};
		end else if (stk_hit_s1) begin
			top = stk_byp_s1;
		end else begin
			top = stk_ent_t'(stk_rdata);
		end
	end

	hgt_exec u_exec (
		.item  (item_s1),
		.ent   (ent),
		.top   (top),
		.depth (depth_q),
		.res   (res),
		.upd   (upd)
	);

	// stage control and bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			depth_q    <= DEPTH_W'(SLOT_COUNT);
			slot_vld_q <= '0;
			stk_vld_q  <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (go) begin
				vld_s1 <= 1'b0;
			end
			depth_q <= depth_nxt;
			if (slot_we) begin
				slot_vld_q[upd.slot_waddr] <= 1'b1;
			end
			if (stk_we) begin
				stk_vld_q[upd.stk_waddr] <= 1'b1;
			end
			if (go) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload of the stage, with forwarding of a same-cycle write
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= in_item;
			slot_vld_s1 <= slot_fwd || slot_vld_q[in_item.idx];
			slot_hit_s1 <= slot_fwd;
			slot_byp_s1 <= upd.slot_wdata;
			stk_vld_s1  <= stk_fwd || stk_vld_q[stk_raddr];
			stk_hit_s1  <= stk_fwd;
			stk_byp_s1  <= upd.stk_wdata;
			stk_addr_s1 <= stk_raddr;
		end
		if (go) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	// stack never holds more entries than the table has slots
	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(SLOT_COUNT))
		else $error("free depth beyond slot count");

	// an item either pops or pushes, never both
	a_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> !(upd.push && upd.pop))
		else $error("push and pop from one item");

	// a successful reserve takes exactly one stack entry
	a_pop_depth: assert property (@(posedge clk) disable iff (!arst_n)
		go && upd.pop |=> depth_q == $past(depth_q) - DEPTH_W'(1))
		else $error("reserve did not lower free depth by one");

	// a recycle is only ever reported together with success
	a_rec_ok: assert property (@(posedge clk) disable iff (!arst_n)
		go && res.recycled |-> res.ok && res.status == ST_OK)
		else $error("recycle without success");

	// a stalled result is held until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !m_tready |=> out_vld_q && $stable(out_q))
		else $error("result changed while stalled");

endmodule
